// ===== sv/graph_next_hop_dijkstra_assert.svh =====
// Assertion macros shared by the graph next-hop block.
`ifndef GRAPH_NEXT_HOP_DIJKSTRA_ASSERT_SVH
`define GRAPH_NEXT_HOP_DIJKSTRA_ASSERT_SVH
`ifndef ASSERT_OFF
`define GNH_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GNH_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GNH_ASSERT(lbl, clk, rst_n, prop, msg)
`define GNH_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== sv/gnh_pkg.sv =====
// Package: constants, operation codes and controller/datapath structs.
package gnh_pkg;

	localparam int GNH_MAX_NODES      = 64;
	localparam int GNH_MAX_NEIGHBOURS = 8;
	localparam int GNH_COST_BITS      = 24;

	localparam int COORD_W = 16;
	localparam int ABS_W   = 16;   // |dx| of two Q12.4 values fits 16 bits
	localparam int SQ_W    = 33;   // dx^2 + dy^2
	localparam int ROOT_W  = 17;   // floor sqrt of SQ_W bits
	localparam int NB_W    = 6;
	localparam int ANS_W   = 7;
	localparam logic [ANS_W-1:0] ANS_NONE = 7'h7F;

	typedef enum logic [2:0] {
		OP_WR_NODE = 3'd0,
		OP_WR_NB   = 3'd1,
		OP_LOCK    = 3'd2,
		OP_NEAR    = 3'd3,
		OP_HOP     = 3'd4
	} op_t;

	typedef struct packed {
		logic take;
		logic node_wr;
		logic nb_wr;
		logic lock_rd;
		logic lock_wr;
		logic near_init;
		logic near_rd;
		logic diff_near;
		logic diff_rel;
		logic sq;
		logic near_cmp;
		logic nh_init;
		logic scan_clr;
		logic scan_rd;
		logic settle;
		logic cur_latch;
		logic adj_rd;
		logic nb_chk;
		logic k_inc;
		logic sqrt_go;
		logic rel_upd;
		logic bt_init;
		logic bt_step;
		logic ans_none;
		logic ans_tgt;
		logic ans_hop;
		logic ans_best;
		logic out_load;
	} gnh_cmd_t;

	typedef struct packed {
		op_t  op;
		logic req_fire;
		logic wr_ok;
		logic slot_ok;
		logic lock_ok;
		logic cnt_zero;
		logic i_last;
		logic ends_bad;
		logic ends_same;
		logic cur_vld;
		logic cur_is_tgt;
		logic len_done;
		logic nb_skip;
		logic pos_locked;
		logic sqrt_done;
		logic bt_hit;
		logic out_full;
	} gnh_sts_t;

endpackage

// ===== sv/gnh_ifs.sv =====
// Valid/ready channel interfaces for requests and results.
interface gnh_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic [5:0]         node_index;
	logic signed [15:0] coord_x;
	logic signed [15:0] coord_y;
	logic               lock_flag;
	logic [3:0]         neighbour_total;
	logic [2:0]         neighbour_slot;
	logic [5:0]         neighbour_node;
	logic signed [6:0]  start_node;
	logic signed [6:0]  target_node;

	modport source (output valid, operation, node_index, coord_x, coord_y, lock_flag,
		neighbour_total, neighbour_slot, neighbour_node, start_node, target_node,
		input ready);
	modport sink (input valid, operation, node_index, coord_x, coord_y, lock_flag,
		neighbour_total, neighbour_slot, neighbour_node, start_node, target_node,
		output ready);
endinterface

interface gnh_rsp_if;
	logic              valid;
	logic              ready;
	logic signed [6:0] answer_node;

	modport source (output valid, answer_node, input ready);
	modport sink (input valid, answer_node, output ready);
endinterface

// ===== sv/gnh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gnh_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [$clog2(D)-1:0] wr_addr,
	input  logic [W-1:0]         wr_data,
	input  logic                 rd_en,
	input  logic [$clog2(D)-1:0] rd_addr,
	output logic [W-1:0]         rd_data
);
	logic [W-1:0] mem_q [D];
	logic [W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ===== sv/gnh_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module gnh_isqrt import gnh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   value,
	output logic              done,
	output logic [ROOT_W-1:0] root
);
	localparam int IW = 2 * ROOT_W;
	localparam int RW = ROOT_W + 3;
	localparam int CW = $clog2(ROOT_W + 1);

	logic [IW-1:0]     val_q;
	logic [RW-1:0]     rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [RW-1:0]     rem_sh;
	logic [RW-1:0]     trial;
	logic              fits;

	assign rem_sh = {rem_q[RW-3:0], val_q[IW-1 -: 2]};
	assign trial  = RW'({root_q, 2'b01});
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(ROOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= IW'(value);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[IW-3:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = !busy_q;
	assign root = root_q;
endmodule

// ===== sv/gnh_ctrl.sv =====
// Controller: sequences writes, nearest scan and shortest-path search.
`include "graph_next_hop_dijkstra_assert.svh"
module gnh_ctrl import gnh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  gnh_sts_t sts,
	output gnh_cmd_t cmd
);
	typedef enum logic [4:0] {
		ST_IDLE, ST_DEC, ST_LOCK_WR,
		ST_NEAR_RD, ST_NEAR_DIFF, ST_NEAR_SQ, ST_NEAR_CMP, ST_NEAR_ANS,
		ST_SCAN_BEGIN, ST_SCAN, ST_SCAN_END, ST_SCAN_CHK,
		ST_CUR, ST_ADJ, ST_NB, ST_POS, ST_SQ, ST_ROOT, ST_WAIT, ST_UPD,
		ST_BT_CHK, ST_RESP
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.take = 1'b1;
				if (sts.req_fire) state_d = ST_DEC;
			end
			ST_DEC: begin
				state_d = ST_IDLE;
				case (sts.op)
					OP_WR_NODE: cmd.node_wr = sts.wr_ok;
					OP_WR_NB:   cmd.nb_wr = sts.wr_ok && sts.slot_ok;
					OP_LOCK: begin
						if (sts.lock_ok) begin
							cmd.lock_rd = 1'b1;
							state_d     = ST_LOCK_WR;
						end
					end
					OP_NEAR: begin
						cmd.near_init = 1'b1;
						if (sts.cnt_zero) begin
							cmd.ans_none = 1'b1;
							state_d      = ST_RESP;
						end else begin
							state_d = ST_NEAR_RD;
						end
					end
					OP_HOP: begin
						state_d = ST_RESP;
						if (sts.ends_bad) begin
							cmd.ans_none = 1'b1;
						end else if (sts.ends_same) begin
							cmd.ans_tgt = 1'b1;
						end else begin
							cmd.nh_init = 1'b1;
							state_d     = ST_SCAN_BEGIN;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_LOCK_WR: begin
				cmd.lock_wr = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_NEAR_RD: begin
				cmd.near_rd = 1'b1;
				state_d     = ST_NEAR_DIFF;
			end
			ST_NEAR_DIFF: begin
				cmd.diff_near = 1'b1;
				state_d       = ST_NEAR_SQ;
			end
			ST_NEAR_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_NEAR_CMP;
			end
			ST_NEAR_CMP: begin
				cmd.near_cmp = 1'b1;
				state_d      = sts.i_last ? ST_NEAR_ANS : ST_NEAR_RD;
			end
			ST_NEAR_ANS: begin
				cmd.ans_best = 1'b1;
				state_d      = ST_RESP;
			end
			ST_SCAN_BEGIN: begin
				cmd.scan_clr = 1'b1;
				state_d      = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.i_last) state_d = ST_SCAN_END;
			end
			ST_SCAN_END: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (!sts.cur_vld) begin
					cmd.ans_none = 1'b1;
					state_d      = ST_RESP;
				end else if (sts.cur_is_tgt) begin
					cmd.bt_init = 1'b1;
					state_d     = ST_BT_CHK;
				end else begin
					cmd.settle = 1'b1;
					state_d    = ST_CUR;
				end
			end
			ST_CUR: begin
				cmd.cur_latch = 1'b1;
				state_d       = ST_ADJ;
			end
			ST_ADJ: begin
				if (sts.len_done) begin
					state_d = ST_SCAN_BEGIN;
				end else begin
					cmd.adj_rd = 1'b1;
					state_d    = ST_NB;
				end
			end
			ST_NB: begin
				if (sts.nb_skip) begin
					cmd.k_inc = 1'b1;
					state_d   = ST_ADJ;
				end else begin
					cmd.nb_chk = 1'b1;
					state_d    = ST_POS;
				end
			end
			ST_POS: begin
				if (sts.pos_locked) begin
					cmd.k_inc = 1'b1;
					state_d   = ST_ADJ;
				end else begin
					cmd.diff_rel = 1'b1;
					state_d      = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.sqrt_go = 1'b1;
				state_d     = ST_WAIT;
			end
			ST_WAIT: begin
				if (sts.sqrt_done) state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.rel_upd = 1'b1;
				state_d     = ST_ADJ;
			end
			ST_BT_CHK: begin
				if (sts.bt_hit) begin
					cmd.ans_hop = 1'b1;
					state_d     = ST_RESP;
				end else begin
					cmd.bt_step = 1'b1;
				end
			end
			ST_RESP: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`GNH_ASSERT(a_out_free, clk, arst_n, cmd.out_load |-> !sts.out_full, "result loaded over a pending result")
	`GNH_ASSERT(a_root_busy, clk, arst_n, cmd.sqrt_go |=> !sts.sqrt_done, "root unit did not start")
	`GNH_ASSERT(a_settle_ok, clk, arst_n, cmd.settle |-> (sts.cur_vld && !sts.cur_is_tgt), "settled a bad node")
	`GNH_NEVER(a_node_rd_one, clk, arst_n, !$onehot0({cmd.lock_rd, cmd.near_rd, cmd.settle, cmd.nb_chk}), "node RAM read conflict")
endmodule

// ===== sv/gnh_dp.sv =====
// Datapath: graph stores, search working stores, distance and root units.
module gnh_dp import gnh_pkg::*; #(
	parameter int MAX_NODES      = GNH_MAX_NODES,
	parameter int MAX_NEIGHBOURS = GNH_MAX_NEIGHBOURS,
	parameter int COST_BITS      = GNH_COST_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,
	gnh_req_if.sink     req,
	gnh_rsp_if.source   rsp,
	input  gnh_cmd_t    cmd,
	output gnh_sts_t    sts
);
	localparam int NW     = $clog2(MAX_NODES);
	localparam int CNTW   = $clog2(MAX_NODES + 1);
	localparam int LW     = $clog2(MAX_NEIGHBOURS + 1);
	localparam int AW     = $clog2(MAX_NODES * MAX_NEIGHBOURS);
	localparam int NODE_W = 2 * COORD_W + 1 + LW;
	localparam int BW     = (COST_BITS > SQ_W) ? COST_BITS : SQ_W;

	// request
	logic [2:0]         op_q;
	logic [5:0]         idx_q;
	logic signed [15:0] x_q, y_q;
	logic               lock_q;
	logic [3:0]         total_q;
	logic [2:0]         slot_q;
	logic [5:0]         nbn_q;
	logic [6:0]         start_q, tgt_q;

	logic [6:0]      cnt_cfg_q;
	logic [CNTW-1:0] act_cnt;

	// node store
	logic              node_wr_en, node_rd_en;
	logic [NW-1:0]     node_rd_addr, node_addr_s1;
	logic [NODE_W-1:0] node_wr_data, node_rd_data;
	logic [MAX_NODES-1:0] node_vld_q;
	logic signed [15:0] nd_x, nd_y;
	logic              nd_lk, rd_vld;
	logic [LW-1:0]     nd_len, len_sat;

	// adjacency store
	logic [AW-1:0]   adj_wr_addr, adj_rd_addr;
	logic [NB_W-1:0] adj_rd_data;

	// search stores
	logic                 cost_wr_en, cost_rd_en;
	logic [NW-1:0]        cost_wr_addr, cost_rd_addr;
	logic [COST_BITS-1:0] cost_wr_data, cost_rd_data;
	logic                 pred_rd_en;
	logic [NW-1:0]        pred_rd_addr, pred_rd_data;
	logic [MAX_NODES-1:0] settled_q, reached_q;

	// loop state
	logic [NW-1:0]   i_q, cur_q, n_q, hop_q, scan_idx_s1;
	logic [LW-1:0]   k_q, cur_len_q;
	logic            scan_vld_s1;
	logic [BW-1:0]   best_q;
	logic            best_vld_q;
	logic signed [15:0] cur_x_q, cur_y_q;

	// distance
	logic [16:0]       dx, dy;
	logic [ABS_W-1:0]  abs_x_q, abs_y_q;
	logic              lk_q;
	logic [31:0]       sq_x_q, sq_y_q;
	logic [SQ_W-1:0]   sq_sum;
	logic [ROOT_W-1:0] root;
	logic              root_done;

	logic [COST_BITS:0]   sum_w;
	logic [COST_BITS-1:0] sum_sat;
	logic                 better;
	logic [NW-1:0]        start_n, tgt_n;

	logic [ANS_W-1:0] ans_q, out_ans_q;
	logic             out_vld_q;

	// ---------------- request capture and count ----------------
	always_ff @(posedge clk) begin
		if (req.valid && cmd.take) begin
			op_q    <= req.operation;
			idx_q   <= req.node_index;
			x_q     <= req.coord_x;
			y_q     <= req.coord_y;
			lock_q  <= req.lock_flag;
			total_q <= req.neighbour_total;
			slot_q  <= req.neighbour_slot;
			nbn_q   <= req.neighbour_node;
			start_q <= req.start_node;
			tgt_q   <= req.target_node;
		end
	end
	assign req.ready = cmd.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_cfg_q <= '0;
		end else if (cfg_wr_en) begin
			cnt_cfg_q <= cfg_wr_data;
		end
	end
	assign act_cnt = (32'(cnt_cfg_q) > MAX_NODES) ? CNTW'(MAX_NODES) : CNTW'(cnt_cfg_q);
	assign start_n = NW'(start_q[5:0]);
	assign tgt_n   = NW'(tgt_q[5:0]);

	// ---------------- node store ----------------
	assign nd_x   = node_rd_data[NODE_W-1 -: COORD_W];
	assign nd_y   = node_rd_data[NODE_W-COORD_W-1 -: COORD_W];
	assign nd_lk  = node_rd_data[LW];
	assign nd_len = node_rd_data[LW-1:0];
	assign rd_vld = node_vld_q[node_addr_s1];
	assign len_sat = (32'(total_q) > MAX_NEIGHBOURS) ? LW'(MAX_NEIGHBOURS) : LW'(total_q);

	assign node_wr_en   = cmd.node_wr | cmd.lock_wr;
	assign node_wr_data = cmd.lock_wr ?
		{nd_x, nd_y, lock_q, (rd_vld ? nd_len : LW'(0))} : {x_q, y_q, lock_q, len_sat};
	assign node_rd_en   = cmd.lock_rd | cmd.near_rd | cmd.settle | cmd.nb_chk;

	always_comb begin
		node_rd_addr = NW'(idx_q);
		if (cmd.near_rd) node_rd_addr = i_q;
		if (cmd.settle)  node_rd_addr = cur_q;
		if (cmd.nb_chk)  node_rd_addr = NW'(adj_rd_data);
	end

	gnh_ram #(.W(NODE_W), .D(MAX_NODES)) u_node_ram (
		.clk(clk), .wr_en(node_wr_en), .wr_addr(NW'(idx_q)), .wr_data(node_wr_data),
		.rd_en(node_rd_en), .rd_addr(node_rd_addr), .rd_data(node_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_vld_q <= '0;
		end else if (node_wr_en) begin
			node_vld_q[NW'(idx_q)] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (node_rd_en) node_addr_s1 <= node_rd_addr;
	end

	// ---------------- adjacency store ----------------
	assign adj_wr_addr = AW'(32'(idx_q) * MAX_NEIGHBOURS + 32'(slot_q));
	assign adj_rd_addr = AW'(32'(cur_q) * MAX_NEIGHBOURS + 32'(k_q));

	gnh_ram #(.W(NB_W), .D(MAX_NODES * MAX_NEIGHBOURS)) u_adj_ram (
		.clk(clk), .wr_en(cmd.nb_wr), .wr_addr(adj_wr_addr), .wr_data(nbn_q),
		.rd_en(cmd.adj_rd), .rd_addr(adj_rd_addr), .rd_data(adj_rd_data)
	);

	// ---------------- cost and predecessor stores ----------------
	assign sum_w   = (COST_BITS+1)'(best_q[COST_BITS-1:0]) + (COST_BITS+1)'(root);
	assign sum_sat = sum_w[COST_BITS] ? {COST_BITS{1'b1}} : sum_w[COST_BITS-1:0];
	assign better  = !reached_q[n_q] || (sum_sat < cost_rd_data);

	assign cost_wr_en   = cmd.nh_init | (cmd.rel_upd & better);
	assign cost_wr_addr = cmd.nh_init ? start_n : n_q;
	assign cost_wr_data = cmd.nh_init ? '0 : sum_sat;
	assign cost_rd_en   = cmd.scan_rd | cmd.diff_rel;
	assign cost_rd_addr = cmd.scan_rd ? i_q : n_q;

	gnh_ram #(.W(COST_BITS), .D(MAX_NODES)) u_cost_ram (
		.clk(clk), .wr_en(cost_wr_en), .wr_addr(cost_wr_addr), .wr_data(cost_wr_data),
		.rd_en(cost_rd_en), .rd_addr(cost_rd_addr), .rd_data(cost_rd_data)
	);

	assign pred_rd_en   = cmd.bt_init | cmd.bt_step;
	assign pred_rd_addr = cmd.bt_init ? tgt_n : pred_rd_data;

	gnh_ram #(.W(NW), .D(MAX_NODES)) u_pred_ram (
		.clk(clk), .wr_en(cmd.rel_upd & better), .wr_addr(n_q), .wr_data(cur_q),
		.rd_en(pred_rd_en), .rd_addr(pred_rd_addr), .rd_data(pred_rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.nh_init) begin
			settled_q          <= '0;
			reached_q          <= '0;
			reached_q[start_n] <= 1'b1;
		end else begin
			if (cmd.settle) settled_q[cur_q] <= 1'b1;
			if (cmd.rel_upd && better) reached_q[n_q] <= 1'b1;
		end
	end

	// ---------------- loop counters, minimum search ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
			best_vld_q  <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan_rd & reached_q[i_q] & ~settled_q[i_q];
			if (cmd.near_init || cmd.scan_clr) begin
				best_vld_q <= 1'b0;
			end else if ((scan_vld_s1 && (!best_vld_q || BW'(cost_rd_data) < best_q)) ||
					(cmd.near_cmp && !lk_q && (!best_vld_q || BW'(sq_sum) < best_q))) begin
				best_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= i_q;
		if (cmd.near_init || cmd.scan_clr) begin
			i_q <= '0;
		end else if (cmd.near_cmp || cmd.scan_rd) begin
			i_q <= i_q + NW'(1);
		end
		if (scan_vld_s1 && (!best_vld_q || BW'(cost_rd_data) < best_q)) begin
			best_q <= BW'(cost_rd_data);
			cur_q  <= scan_idx_s1;
		end else if (cmd.near_cmp && !lk_q && (!best_vld_q || BW'(sq_sum) < best_q)) begin
			best_q <= BW'(sq_sum);
			cur_q  <= i_q;
		end
		if (cmd.settle) begin
			k_q <= '0;
		end else if (cmd.k_inc || cmd.rel_upd) begin
			k_q <= k_q + LW'(1);
		end
		if (cmd.cur_latch) begin
			cur_x_q   <= nd_x;
			cur_y_q   <= nd_y;
			cur_len_q <= rd_vld ? nd_len : LW'(0);
		end
		if (cmd.nb_chk) n_q <= NW'(adj_rd_data);
		if (cmd.bt_init) begin
			hop_q <= tgt_n;
		end else if (cmd.bt_step) begin
			hop_q <= pred_rd_data;
		end
	end

	// ---------------- distance: diff, square, root ----------------
	assign dx = {nd_x[15], nd_x} - (cmd.diff_near ? {x_q[15], x_q} : {cur_x_q[15], cur_x_q});
	assign dy = {nd_y[15], nd_y} - (cmd.diff_near ? {y_q[15], y_q} : {cur_y_q[15], cur_y_q});

	always_ff @(posedge clk) begin
		if (cmd.diff_near || cmd.diff_rel) begin
			abs_x_q <= dx[16] ? ABS_W'(17'd0 - dx) : dx[ABS_W-1:0];
			abs_y_q <= dy[16] ? ABS_W'(17'd0 - dy) : dy[ABS_W-1:0];
			lk_q    <= rd_vld & nd_lk;
		end
		if (cmd.sq) begin
			sq_x_q <= 32'(abs_x_q) * 32'(abs_x_q);
			sq_y_q <= 32'(abs_y_q) * 32'(abs_y_q);
		end
	end
	assign sq_sum = {1'b0, sq_x_q} + {1'b0, sq_y_q};

	gnh_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_go), .value(sq_sum),
		.done(root_done), .root(root)
	);

	// ---------------- answer and result register ----------------
	always_ff @(posedge clk) begin
		if (cmd.ans_none) ans_q <= ANS_NONE;
		if (cmd.ans_tgt)  ans_q <= tgt_q;
		if (cmd.ans_hop)  ans_q <= ANS_W'(hop_q);
		if (cmd.ans_best) ans_q <= best_vld_q ? ANS_W'(cur_q) : ANS_NONE;
		if (cmd.out_load) out_ans_q <= ans_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end
	assign rsp.valid       = out_vld_q;
	assign rsp.answer_node = out_ans_q;

	// ---------------- status ----------------
	assign sts.op         = op_t'(op_q);
	assign sts.req_fire   = req.valid & cmd.take;
	assign sts.wr_ok      = 32'(idx_q) < MAX_NODES;
	assign sts.slot_ok    = 32'(slot_q) < MAX_NEIGHBOURS;
	assign sts.lock_ok    = 32'(idx_q) < 32'(act_cnt);
	assign sts.cnt_zero   = act_cnt == '0;
	assign sts.i_last     = (CNTW'(i_q) + CNTW'(1)) == act_cnt;
	assign sts.ends_bad   = start_q[6] | tgt_q[6] | (32'(start_q[5:0]) >= 32'(act_cnt)) |
		(32'(tgt_q[5:0]) >= 32'(act_cnt));
	assign sts.ends_same  = start_q == tgt_q;
	assign sts.cur_vld    = best_vld_q;
	assign sts.cur_is_tgt = cur_q == tgt_n;
	assign sts.len_done   = k_q >= cur_len_q;
	assign sts.nb_skip    = (32'(adj_rd_data) >= 32'(act_cnt)) | settled_q[NW'(adj_rd_data)];
	assign sts.pos_locked = rd_vld & nd_lk;
	assign sts.sqrt_done  = root_done;
	assign sts.bt_hit     = pred_rd_data == start_n;
	assign sts.out_full   = out_vld_q;
endmodule

// ===== sv/graph_next_hop_dijkstra.sv =====
// Top level of the graph next-hop block: controller plus datapath.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  req     | in  | valid/ready        | operation, node_index, coords, lock, neighbour
//          |     |                    | fields, start_node, target_node
//  rsp     | out | valid/ready        | answer_node (-1 when none)
//  cfg     | in  | cfg_wr_en, no wait | cfg_wr_data = node_count
//
// A next hop query settles nodes one at a time: each settle costs a scan of
// all nodes in use through the single cost RAM read port, plus a distance
// and a square-root pass for each neighbour that is not skipped or locked.
// Reset clears node valid flags at once, masking lock bits; no clearing pass.
// One item is in work at a time; a result waits in the output register while
// the next item is taken, and the block stalls only to load a result over one
// that has not yet been transferred.
module graph_next_hop_dijkstra import gnh_pkg::*; #(
	parameter int MAX_NODES      = GNH_MAX_NODES,
	parameter int MAX_NEIGHBOURS = GNH_MAX_NEIGHBOURS,
	parameter int COST_BITS      = GNH_COST_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	gnh_req_if.sink    req,
	gnh_rsp_if.source  rsp
);
	gnh_cmd_t cmd;   // controller to datapath strobes
	gnh_sts_t sts;   // datapath flags back to the controller

	// sequencer: one state per step of the search
	gnh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .cmd(cmd)
	);

	// stores, counters, distance and root units, result register
	gnh_dp #(
		.MAX_NODES(MAX_NODES), .MAX_NEIGHBOURS(MAX_NEIGHBOURS), .COST_BITS(COST_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.req(req), .rsp(rsp), .cmd(cmd), .sts(sts)
	);
endmodule

// ===== bench/gnh_checker.sv =====
// Checker for the graph next-hop block: watches the channels, predicts answers, compares.
`timescale 1ns / 1ps
module gnh_checker import gnh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	gnh_req_if         req,
	gnh_rsp_if         rsp,
	output int         errors,
	output int         pending
);
	localparam longint COST_SAT = (64'd1 << GNH_COST_BITS) - 1;

	logic [6:0]         node_count;
	logic signed [15:0] pos_x [GNH_MAX_NODES];
	logic signed [15:0] pos_y [GNH_MAX_NODES];
	bit                 locked [GNH_MAX_NODES];
	int                 adj_len [GNH_MAX_NODES];
	logic [5:0]         adj_tab [GNH_MAX_NODES*GNH_MAX_NEIGHBOURS];
	logic [6:0]         answers_due [$];

	function automatic int active_nodes();
		return (node_count > GNH_MAX_NODES) ? GNH_MAX_NODES : int'(node_count);
	endfunction

	function automatic longint sq_dist(int dx, int dy);
		return longint'(dx) * dx + longint'(dy) * dy;
	endfunction

	function automatic longint int_sqrt(longint v);
		longint res;
		longint bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [6:0] nearest_node(int x, int y);
		int     best_idx;
		longint best;
		longint d;
		best_idx = -1;
		best     = 0;
		for (int i = 0; i < active_nodes(); i++) begin
			d = sq_dist(int'(pos_x[i]) - x, int'(pos_y[i]) - y);
			if (!locked[i] && (best_idx < 0 || d < best)) begin
				best_idx = i;
				best     = d;
			end
		end
		return (best_idx < 0) ? ANS_NONE : best_idx[6:0];
	endfunction

	function automatic logic [6:0] first_hop(int s, int t);
		longint cost [GNH_MAX_NODES];
		int     pred [GNH_MAX_NODES];
		bit     done [GNH_MAX_NODES];
		bit     seen [GNH_MAX_NODES];
		int     cnt, cur, n, hop, p;
		longint best, sum;
		bit     found;
		cnt = active_nodes();
		if (s < 0 || s >= cnt || t < 0 || t >= cnt) return ANS_NONE;
		if (s == t) return t[6:0];
		for (int i = 0; i < cnt; i++) begin
			cost[i] = 0;
			pred[i] = -1;
			done[i] = 0;
			seen[i] = 0;
		end
		seen[s] = 1;
		found   = 0;
		for (int step = 0; step < cnt; step++) begin
			cur  = -1;
			best = 0;
			for (int i = 0; i < cnt; i++)
				if (!done[i] && seen[i] && (cur < 0 || cost[i] < best)) begin
					cur  = i;
					best = cost[i];
				end
			if (cur < 0) return ANS_NONE;
			if (cur == t) begin
				found = 1;
				break;
			end
			done[cur] = 1;
			for (int k = 0; k < adj_len[cur]; k++) begin
				n = int'(adj_tab[cur*GNH_MAX_NEIGHBOURS + k]);
				if (n >= cnt || locked[n] || done[n]) continue;
				sum = best + int_sqrt(sq_dist(int'(pos_x[n]) - int'(pos_x[cur]),
					int'(pos_y[n]) - int'(pos_y[cur])));
				if (sum > COST_SAT) sum = COST_SAT;
				if (!seen[n] || sum < cost[n]) begin
					seen[n] = 1;
					cost[n] = sum;
					pred[n] = cur;
				end
			end
		end
		if (!found) return ANS_NONE;
		hop = t;
		for (int g = 0; g <= cnt; g++) begin
			p = pred[hop];
			if (p == s) return hop[6:0];
			if (p < 0) return ANS_NONE;
			hop = p;
		end
		return ANS_NONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int total;
		if (!arst_n) begin
			node_count = '0;
			errors     = 0;
			for (int i = 0; i < GNH_MAX_NODES; i++) begin
				locked[i]  = 0;
				adj_len[i] = 0;
				pos_x[i]   = '0;
				pos_y[i]   = '0;
			end
			answers_due.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (answers_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: unexpected answer %0d", $signed(rsp.answer_node));
				end else if (rsp.answer_node !== answers_due[0]) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: answer expected %0d got %0d",
							$signed(answers_due[0]), $signed(rsp.answer_node));
					void'(answers_due.pop_front());
				end else begin
					void'(answers_due.pop_front());
				end
			end
			if (req.valid && req.ready) begin
				case (req.operation)
					OP_WR_NODE: begin
						total = (req.neighbour_total > GNH_MAX_NEIGHBOURS) ?
							GNH_MAX_NEIGHBOURS : int'(req.neighbour_total);
						pos_x[req.node_index]   = req.coord_x;
						pos_y[req.node_index]   = req.coord_y;
						locked[req.node_index]  = req.lock_flag;
						adj_len[req.node_index] = total;
					end
					OP_WR_NB:
						adj_tab[req.node_index*GNH_MAX_NEIGHBOURS + req.neighbour_slot] =
							req.neighbour_node;
					OP_LOCK:
						if (req.node_index < active_nodes())
							locked[req.node_index] = req.lock_flag;
					OP_NEAR:
						answers_due.push_back(nearest_node(int'(req.coord_x), int'(req.coord_y)));
					OP_HOP:
						answers_due.push_back(first_hop(int'(req.start_node),
							int'(req.target_node)));
					default: ;
				endcase
			end
			if (cfg_wr_en) node_count = cfg_wr_data;
		end
		pending = answers_due.size();
	end
endmodule

// ===== bench/tb_graph_next_hop_dijkstra.sv =====
// Testbench top for the graph next-hop block: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module tb_graph_next_hop_dijkstra;
	import gnh_pkg::*;

	// one request as driven onto the channel
	typedef struct {
		logic [2:0]         operation;
		logic [5:0]         node_index;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic               lock_flag;
		logic [3:0]         neighbour_total;
		logic [2:0]         neighbour_slot;
		logic [5:0]         neighbour_node;
		logic signed [6:0]  start_node;
		logic signed [6:0]  target_node;
	} graph_req_t;

	localparam int WATCHDOG_LIMIT = 400000;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [6:0] cfg_wr_data;
	int         errors;
	int         pending;
	int         gap_pct;
	int         stall_pct;
	int         quiet_cycles;
	int         node_total;
	int         slot_prefix [64];   // slots 0..prefix-1 written

	gnh_req_if req ();
	gnh_rsp_if rsp ();

	graph_next_hop_dijkstra u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.rsp         (rsp)
	);

	gnh_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.rsp         (rsp),
		.errors      (errors),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver side: ready changes at the falling edge only
	always @(negedge clk)
		rsp.ready = ($urandom_range(0, 99) >= stall_pct);

	// watchdog: cycles in which no transfer happens on either channel
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// random fill of every field, then the caller overrides what matters
	function automatic graph_req_t rand_item(logic [2:0] op);
		graph_req_t it;
		it.operation       = op;
		it.node_index      = 6'($urandom);
		it.coord_x         = 16'($urandom);
		it.coord_y         = 16'($urandom);
		it.lock_flag       = 1'($urandom);
		it.neighbour_total = 4'($urandom);
		it.neighbour_slot  = 3'($urandom);
		it.neighbour_node  = 6'($urandom);
		it.start_node      = 7'($urandom);
		it.target_node     = 7'($urandom);
		return it;
	endfunction

	// mostly a coarse grid so that distance ties show up; now and then a full-range value
	function automatic logic signed [15:0] rand_coord();
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		return 16'(($urandom_range(0, 40) - 20) * 64);
	endfunction

	// one transfer on the request channel, with a random gap before it
	task automatic send(input graph_req_t it);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			req.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req.valid           = 1'b1;
		req.operation       = it.operation;
		req.node_index      = it.node_index;
		req.coord_x         = it.coord_x;
		req.coord_y         = it.coord_y;
		req.lock_flag       = it.lock_flag;
		req.neighbour_total = it.neighbour_total;
		req.neighbour_slot  = it.neighbour_slot;
		req.neighbour_node  = it.neighbour_node;
		req.start_node      = it.start_node;
		req.target_node     = it.target_node;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	// write one slot and keep track of the written prefix
	task automatic write_slot(input int node, input int slot, input int nb);
		graph_req_t it;
		it                = rand_item(OP_WR_NB);
		it.node_index     = 6'(node);
		it.neighbour_slot = 3'(slot);
		it.neighbour_node = 6'(nb);
		send(it);
		if (slot == slot_prefix[node]) slot_prefix[node]++;
	endtask

	// write a node; the neighbour total never reaches past written slots
	task automatic write_node(input int node, input int total, input bit lock);
		graph_req_t it;
		int eff;
		eff = (total > 8) ? 8 : total;
		while (slot_prefix[node] < eff)
			write_slot(node, slot_prefix[node],
				(node_total > 0 && $urandom_range(0, 4) != 0) ?
				$urandom_range(0, node_total - 1) : $urandom_range(0, 63));
		it                 = rand_item(OP_WR_NODE);
		it.node_index      = 6'(node);
		it.coord_x         = rand_coord();
		it.coord_y         = rand_coord();
		it.lock_flag       = lock;
		it.neighbour_total = 4'(total);
		send(it);
	endtask

	// config writes only while the block has nothing in work
	task automatic set_count(input int value);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = 7'(value);
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		node_total  = (value > 64) ? 64 : value;
	endtask

	// fresh graph over the nodes in use
	task automatic build_graph();
		for (int i = 0; i < node_total; i++)
			write_node(i, ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) :
				$urandom_range(0, 5), $urandom_range(0, 9) == 0);
	endtask

	task automatic query_near(input logic signed [15:0] x, input logic signed [15:0] y);
		graph_req_t it;
		it         = rand_item(OP_NEAR);
		it.coord_x = x;
		it.coord_y = y;
		send(it);
	endtask

	task automatic query_hop(input int s, input int t);
		graph_req_t it;
		it             = rand_item(OP_HOP);
		it.start_node  = 7'(s);
		it.target_node = 7'(t);
		send(it);
	endtask

	// endpoint mostly inside the graph, sometimes anywhere in the 7-bit range
	function automatic int rand_end();
		if (node_total == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 127) - 64;
		return $urandom_range(0, node_total - 1);
	endfunction

	// one random item that never reads an entry left unwritten
	task automatic random_item();
		graph_req_t it;
		int pick, node;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			query_near(rand_coord(), rand_coord());
		end else if (pick < 55) begin
			query_hop(rand_end(), rand_end());
		end else if (pick < 70) begin
			it           = rand_item(OP_LOCK);
			it.lock_flag = ($urandom_range(0, 2) == 0);
			send(it);
		end else if (pick < 82) begin
			node = $urandom_range(0, 63);
			write_slot(node, $urandom_range(0, 7), (node_total > 0) ?
				$urandom_range(0, node_total - 1) : $urandom_range(0, 63));
		end else if (pick < 95) begin
			node = $urandom_range(0, 63);
			write_node(node, (slot_prefix[node] >= 8) ? $urandom_range(0, 15) :
				$urandom_range(0, slot_prefix[node]), $urandom_range(0, 5) == 0);
		end else begin
			send(rand_item(3'($urandom_range(5, 7))));
		end
	endtask

	initial begin
		graph_req_t it;
		int count_pick;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		gap_pct        = 0;
		stall_pct      = 0;
		quiet_cycles   = 0;
		node_total     = 0;
		req.valid      = 1'b0;
		it             = rand_item(OP_NEAR);
		req.operation       = it.operation;
		req.node_index      = it.node_index;
		req.coord_x         = it.coord_x;
		req.coord_y         = it.coord_y;
		req.lock_flag       = it.lock_flag;
		req.neighbour_total = it.neighbour_total;
		req.neighbour_slot  = it.neighbour_slot;
		req.neighbour_node  = it.neighbour_node;
		req.start_node      = it.start_node;
		req.target_node     = it.target_node;
		for (int i = 0; i < 64; i++)
			slot_prefix[i] = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty graph: both queries answer none; unknown codes are dropped
		query_near(16'sh8000, 16'sh7FFF);
		query_hop(0, 0);
		send(rand_item(3'd5));
		send(rand_item(3'd7));

		// small graph: extremes of the point, bad and equal endpoints
		set_count(4);
		build_graph();
		write_node(3, 15, 1'b1);           // total saturates, node locked
		query_near(16'sh8000, 16'sh8000);
		query_near(16'sh7FFF, 16'sh7FFF);
		query_near(16'sh0000, 16'sh0000);
		query_hop(3, 3);                   // same endpoints, locked target
		query_hop(0, 3);                   // locked target
		query_hop(-1, 2);
		query_hop(1, 4);
		query_hop(-64, 63);
		it            = rand_item(OP_LOCK); // lock beyond the count is dropped
		it.node_index = 6'd50;
		it.lock_flag  = 1'b1;
		send(it);
		it            = rand_item(OP_LOCK); // locked start is still searched from
		it.node_index = 6'd0;
		it.lock_flag  = 1'b1;
		send(it);
		query_hop(0, 1);
		query_hop(0, 2);
		for (int i = 0; i < 4; i++) begin  // all locked: nearest has none
			it            = rand_item(OP_LOCK);
			it.node_index = 6'(i);
			it.lock_flag  = 1'b1;
			send(it);
		end
		query_near(16'sh0040, 16'sh0040);

		// count above the node limit: full scans from a node with no neighbours
		set_count(100);
		query_hop(63, 0);
		set_count(64);
		query_hop(60, 61);

		// random part, four idling phases; small graphs keep queries short
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 78; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 78; end
				default: begin gap_pct = 35; stall_pct = 35; end
			endcase
			count_pick = $urandom_range(0, 9);
			set_count((count_pick == 0) ? $urandom_range(0, 1) : $urandom_range(2, 5));
			build_graph();
			for (int n = 0; n < 6; n++) random_item();
		end

		// drain: all answers in, then a settling pause
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
